// ===== src/wss_pkg.sv =====
// Shared types and constants for the weighted server select block.
`default_nettype none

package wss_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int SIDX_W  = 3;
    localparam int OCC_W   = 16;
    localparam int SCALE_W = 12;
    localparam int CAP_W   = 16;
    localparam int CNT_W   = 16;
    localparam int WT_W    = 12;
    localparam int SUM_W   = 15;   // up to eight weights of at most 4095
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Shared divider sizing: (capacity - occupancy) * scale over capacity
    localparam int DIV_N_W   = CAP_W + SCALE_W;
    localparam int DIV_D_W   = CAP_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // Register reset values
    localparam logic [CAP_W-1:0]   CAP_RESET   = 16'd2500;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'd0,
        CFG_SCALE    = 1'd1
    } t_cfg_reg;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD      = 2'd0,
        CMD_RECOMPUTE = 2'd1,
        CMD_SELECT    = 2'd2,
        CMD_RSVD      = 2'd3
    } t_cmd;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_RAW_MUL,
        OP_RAW_DIV,
        OP_RAW_STORE,
        OP_NRM_MUL,
        OP_NRM_DIV,
        OP_NRM_STORE,
        OP_SCAN,
        OP_SEL_UPD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_push;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic last;       // index register points at the last server
        logic zero;       // current division is skipped, quotient is zero
        logic match;      // draw falls in the interval under the index
        logic div_done;
        logic out_free;   // output register can take a result this cycle
    } t_dp_status;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RAW_MUL,
        S_RAW_DIV,
        S_RAW_WAIT,
        S_NRM_MUL,
        S_NRM_DIV,
        S_NRM_WAIT,
        S_SCAN,
        S_UPD,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/wss_if.sv =====
// Channel interfaces: request input, result output and configuration write.
`default_nettype none

interface wss_in_if;
    logic                          valid;
    logic                          ready;
    logic [wss_pkg::CMD_W-1:0]     command;
    logic [wss_pkg::SIDX_W-1:0]    server_index;
    logic [wss_pkg::OCC_W-1:0]     occupancy_value;
    logic [wss_pkg::SCALE_W-1:0]   random_value;

    modport source (output valid, command, server_index, occupancy_value, random_value,
                    input ready);
    modport sink   (input valid, command, server_index, occupancy_value, random_value,
                    output ready);
endinterface

interface wss_out_if;
    logic                          valid;
    logic                          ready;
    logic [wss_pkg::SIDX_W-1:0]    selected_server;
    logic                          interval_matched;
    logic [wss_pkg::OCC_W-1:0]     occupancy_after;
    logic [wss_pkg::CNT_W-1:0]     times_selected;

    modport source (output valid, selected_server, interval_matched, occupancy_after,
                    times_selected, input ready);
    modport sink   (input valid, selected_server, interval_matched, occupancy_after,
                    times_selected, output ready);
endinterface

interface wss_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wss_pkg::CFG_IDX_W-1:0]     index;
    logic [wss_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/wss_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both recompute passes.
`default_nettype none

module wss_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [wss_pkg::DIV_N_W-1:0]   i_dividend,
    input  wire logic [wss_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic [wss_pkg::DIV_N_W-1:0]        o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [wss_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [wss_pkg::DIV_D_W-1:0]     r_rem;
    logic [wss_pkg::DIV_N_W-1:0]     r_quo;
    logic [wss_pkg::DIV_D_W-1:0]     r_dsr;

    logic [wss_pkg::DIV_D_W:0]       w_shift;
    logic [wss_pkg::DIV_D_W:0]       w_diff;
    logic                            w_ge;

    // One trial subtraction per cycle
    assign w_shift = {r_rem, r_quo[wss_pkg::DIV_N_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});
    assign w_diff  = w_shift - {1'b0, r_dsr};

    // Control: busy window and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= wss_pkg::DIV_CNT_W'(wss_pkg::DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == wss_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[wss_pkg::DIV_D_W-1:0] : w_shift[wss_pkg::DIV_D_W-1:0];
            r_quo <= {r_quo[wss_pkg::DIV_N_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== src/wss_datapath.sv =====
// Datapath: per-server state, weight arithmetic, interval scan and result register.
`default_nettype none

module wss_datapath #(
    parameter int NUM_SERVERS = 5
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [wss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [wss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request payload
    input  wire logic [wss_pkg::CMD_W-1:0]         i_command,
    input  wire logic [wss_pkg::SIDX_W-1:0]        i_server_index,
    input  wire logic [wss_pkg::OCC_W-1:0]         i_occupancy_value,
    input  wire logic [wss_pkg::SCALE_W-1:0]       i_random_value,
    // result channel
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [wss_pkg::SIDX_W-1:0]             o_selected_server,
    output logic                                   o_interval_matched,
    output logic [wss_pkg::OCC_W-1:0]              o_occupancy_after,
    output logic [wss_pkg::CNT_W-1:0]              o_times_selected,
    // controller link
    input  wire wss_pkg::t_dp_cmd                  i_cmd,
    output wss_pkg::t_dp_status                    o_status
);

    localparam int IDX_W = $clog2(NUM_SERVERS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SERVERS - 1);
    localparam int NRM_W = wss_pkg::WT_W + wss_pkg::SCALE_W;

    // Configuration registers
    logic [wss_pkg::CAP_W-1:0]     r_cap;
    logic [wss_pkg::SCALE_W-1:0]   r_scale;

    // Per-server state
    logic [wss_pkg::OCC_W-1:0]     r_occ [NUM_SERVERS];
    logic [wss_pkg::WT_W-1:0]      r_wt  [NUM_SERVERS];
    logic [wss_pkg::WT_W-1:0]      r_off [NUM_SERVERS];
    logic [wss_pkg::CNT_W-1:0]     r_cnt [NUM_SERVERS];
    logic [wss_pkg::WT_W-1:0]      r_raw [NUM_SERVERS];

    // Captured request
    wss_pkg::t_cmd                 r_cmd;
    logic [wss_pkg::SIDX_W-1:0]    r_in_idx;
    logic [wss_pkg::OCC_W-1:0]     r_in_occ;
    logic [wss_pkg::SCALE_W-1:0]   r_draw;

    // Working registers
    logic [IDX_W-1:0]              r_idx;
    logic [wss_pkg::DIV_N_W-1:0]   r_prod;
    logic                          r_zero;
    logic [wss_pkg::SUM_W-1:0]     r_sum;
    logic [wss_pkg::WT_W-1:0]      r_run;
    logic                          r_match;

    // Pending result and output register
    logic [wss_pkg::SIDX_W-1:0]    r_res_sel;
    logic                          r_res_match;
    logic [wss_pkg::OCC_W-1:0]     r_res_occ;
    logic [wss_pkg::CNT_W-1:0]     r_res_cnt;
    logic                          r_out_valid;
    logic [wss_pkg::SIDX_W-1:0]    r_out_sel;
    logic                          r_out_match;
    logic [wss_pkg::OCC_W-1:0]     r_out_occ;
    logic [wss_pkg::CNT_W-1:0]     r_out_cnt;

    // Divider link
    logic                          w_div_start;
    logic [wss_pkg::DIV_D_W-1:0]   w_div_dsr;
    logic                          w_div_done;
    logic [wss_pkg::DIV_N_W-1:0]   w_div_quo;

    // Read port at the index register
    logic [wss_pkg::OCC_W-1:0]     w_occ_rd;
    logic [wss_pkg::CNT_W-1:0]     w_cnt_rd;
    logic [wss_pkg::WT_W-1:0]      w_wt_rd;
    logic [wss_pkg::WT_W-1:0]      w_off_rd;
    logic [wss_pkg::WT_W-1:0]      w_raw_rd;
    logic [wss_pkg::OCC_W-1:0]     w_occ_inc;
    logic [wss_pkg::CNT_W-1:0]     w_cnt_inc;
    logic [wss_pkg::CAP_W-1:0]     w_spare;
    logic [wss_pkg::DIV_N_W-1:0]   w_raw_prod;
    logic [NRM_W-1:0]              w_nrm_prod;
    logic [wss_pkg::WT_W-1:0]      w_quo12;
    logic [wss_pkg::WT_W-1:0]      w_new_wt;
    logic [wss_pkg::WT_W-1:0]      w_new_run;
    logic                          w_match;
    logic                          w_load_ok;
    logic                          w_out_free;

    assign w_occ_rd = r_occ[r_idx];
    assign w_cnt_rd = r_cnt[r_idx];
    assign w_wt_rd  = r_wt[r_idx];
    assign w_off_rd = r_off[r_idx];
    assign w_raw_rd = r_raw[r_idx];

    // Saturating increments for the select update
    assign w_occ_inc = (w_occ_rd == '1) ? w_occ_rd : w_occ_rd + 1'b1;
    assign w_cnt_inc = (w_cnt_rd == '1) ? w_cnt_rd : w_cnt_rd + 1'b1;

    // Products feeding the divider
    assign w_spare    = r_cap - w_occ_rd;
    assign w_raw_prod = wss_pkg::DIV_N_W'(w_spare) * wss_pkg::DIV_N_W'(r_scale);
    assign w_nrm_prod = NRM_W'(w_raw_rd) * NRM_W'(r_scale);

    // Quotients never exceed the scale, so the low bits carry the value
    assign w_quo12   = w_div_quo[wss_pkg::WT_W-1:0];
    assign w_new_wt  = r_zero ? '0 : w_quo12;
    assign w_new_run = r_run + w_new_wt;

    // Interval [offset - weight, offset) test for the server under the index
    assign w_match = (w_wt_rd <= w_off_rd) && (r_draw >= (w_off_rd - w_wt_rd))
                     && (r_draw < w_off_rd);

    assign w_load_ok = ({1'b0, r_in_idx} < (wss_pkg::SIDX_W + 1)'(NUM_SERVERS));

    assign w_div_start = (i_cmd.op == wss_pkg::OP_RAW_DIV) || (i_cmd.op == wss_pkg::OP_NRM_DIV);
    assign w_div_dsr   = (i_cmd.op == wss_pkg::OP_NRM_DIV) ? wss_pkg::DIV_D_W'(r_sum) : r_cap;

    wss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= wss_pkg::CAP_RESET;
            r_scale <= wss_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (wss_pkg::t_cfg_reg'(i_cfg_index))
                wss_pkg::CFG_CAPACITY: r_cap   <= i_cfg_data[wss_pkg::CAP_W-1:0];
                wss_pkg::CFG_SCALE:    r_scale <= i_cfg_data[wss_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-server state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SERVERS; i++) begin
                r_occ[i] <= '0;
                r_wt[i]  <= '0;
                r_off[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                wss_pkg::OP_LOAD: begin
                    if (w_load_ok) begin
                        r_occ[r_in_idx[IDX_W-1:0]] <= r_in_occ;
                    end
                end
                wss_pkg::OP_NRM_STORE: begin
                    r_wt[r_idx]  <= w_new_wt;
                    r_off[r_idx] <= w_new_run;
                end
                wss_pkg::OP_SEL_UPD: begin
                    r_occ[r_idx] <= w_occ_inc;
                    r_cnt[r_idx] <= w_cnt_inc;
                end
                default: ;
            endcase
        end
    end

    // Request capture and working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            wss_pkg::OP_CAPTURE: begin
                r_cmd       <= wss_pkg::t_cmd'(i_command);
                r_in_idx    <= i_server_index;
                r_in_occ    <= i_occupancy_value;
                r_draw      <= i_random_value;
                r_idx       <= '0;
                r_sum       <= '0;
                r_run       <= '0;
                r_res_sel   <= '0;
                r_res_match <= 1'b0;
                r_res_occ   <= '0;
                r_res_cnt   <= '0;
            end
            wss_pkg::OP_LOAD: begin
                r_res_occ <= w_load_ok ? r_in_occ : '0;
            end
            wss_pkg::OP_RAW_MUL: begin
                r_prod <= w_raw_prod;
                r_zero <= (r_cap == '0) || (w_occ_rd > r_cap);
            end
            wss_pkg::OP_RAW_STORE: begin
                r_raw[r_idx] <= w_new_wt;
                r_sum        <= r_sum + wss_pkg::SUM_W'(w_new_wt);
                r_idx        <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            wss_pkg::OP_NRM_MUL: begin
                r_prod <= wss_pkg::DIV_N_W'(w_nrm_prod);
                r_zero <= (r_sum == '0);
            end
            wss_pkg::OP_NRM_STORE: begin
                r_run <= w_new_run;
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            wss_pkg::OP_SCAN: begin
                r_match <= w_match;
                if (!w_match && (r_idx != LAST_IDX)) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            wss_pkg::OP_SEL_UPD: begin
                r_res_sel   <= wss_pkg::SIDX_W'(r_idx);
                r_res_match <= r_match;
                r_res_occ   <= w_occ_inc;
                r_res_cnt   <= w_cnt_inc;
            end
            default: ;
        endcase
    end

    // Output register: takes a result while the previous one is being taken
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_push) begin
            r_out_sel   <= r_res_sel;
            r_out_match <= r_res_match;
            r_out_occ   <= r_res_occ;
            r_out_cnt   <= r_res_cnt;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_selected_server  = r_out_sel;
    assign o_interval_matched = r_out_match;
    assign o_occupancy_after  = r_out_occ;
    assign o_times_selected   = r_out_cnt;

    // Status back to the controller
    always_comb begin
        o_status.cmd      = r_cmd;
        o_status.last     = (r_idx == LAST_IDX);
        o_status.zero     = r_zero;
        o_status.match    = w_match;
        o_status.div_done = w_div_done;
        o_status.out_free = w_out_free;
    end

endmodule

`default_nettype wire

// ===== src/wss_ctrl.sv =====
// Controller: sequences load, recompute and select over the datapath.
`default_nettype none

module wss_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire wss_pkg::t_dp_status    i_status,
    output wss_pkg::t_dp_cmd            o_cmd
);

    wss_pkg::t_state r_state;
    wss_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_cmd.op     = wss_pkg::OP_NONE;
        o_cmd.out_push = 1'b0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            wss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = wss_pkg::OP_CAPTURE;
                    n_state  = wss_pkg::S_DECODE;
                end
            end
            wss_pkg::S_DECODE: begin
                unique case (i_status.cmd)
                    wss_pkg::CMD_LOAD: begin
                        o_cmd.op = wss_pkg::OP_LOAD;
                        n_state  = wss_pkg::S_DONE;
                    end
                    wss_pkg::CMD_RECOMPUTE: n_state = wss_pkg::S_RAW_MUL;
                    wss_pkg::CMD_SELECT:    n_state = wss_pkg::S_SCAN;
                    default:                n_state = wss_pkg::S_DONE;
                endcase
            end
            // First pass: raw weight of each server
            wss_pkg::S_RAW_MUL: begin
                o_cmd.op = wss_pkg::OP_RAW_MUL;
                n_state  = wss_pkg::S_RAW_DIV;
            end
            wss_pkg::S_RAW_DIV: begin
                if (i_status.zero) begin
                    o_cmd.op = wss_pkg::OP_RAW_STORE;
                    n_state  = i_status.last ? wss_pkg::S_NRM_MUL : wss_pkg::S_RAW_MUL;
                end else begin
                    o_cmd.op = wss_pkg::OP_RAW_DIV;
                    n_state  = wss_pkg::S_RAW_WAIT;
                end
            end
            wss_pkg::S_RAW_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = wss_pkg::OP_RAW_STORE;
                    n_state  = i_status.last ? wss_pkg::S_NRM_MUL : wss_pkg::S_RAW_MUL;
                end
            end
            // Second pass: normalized weights and running offsets
            wss_pkg::S_NRM_MUL: begin
                o_cmd.op = wss_pkg::OP_NRM_MUL;
                n_state  = wss_pkg::S_NRM_DIV;
            end
            wss_pkg::S_NRM_DIV: begin
                if (i_status.zero) begin
                    o_cmd.op = wss_pkg::OP_NRM_STORE;
                    n_state  = i_status.last ? wss_pkg::S_DONE : wss_pkg::S_NRM_MUL;
                end else begin
                    o_cmd.op = wss_pkg::OP_NRM_DIV;
                    n_state  = wss_pkg::S_NRM_WAIT;
                end
            end
            wss_pkg::S_NRM_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = wss_pkg::OP_NRM_STORE;
                    n_state  = i_status.last ? wss_pkg::S_DONE : wss_pkg::S_NRM_MUL;
                end
            end
            // Walk the intervals until a hit or the last server
            wss_pkg::S_SCAN: begin
                o_cmd.op = wss_pkg::OP_SCAN;
                if (i_status.match || i_status.last) begin
                    n_state = wss_pkg::S_UPD;
                end
            end
            wss_pkg::S_UPD: begin
                o_cmd.op = wss_pkg::OP_SEL_UPD;
                n_state  = wss_pkg::S_DONE;
            end
            wss_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_push = 1'b1;
                    n_state        = wss_pkg::S_IDLE;
                end
            end
            default: n_state = wss_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/weighted_server_select.sv =====
// Weighted server select: one transaction in, one result out per command.
// Load captures the request, writes the occupancy and pushes the result; select scans k servers (1..NUM_SERVERS).
// Recompute makes two passes over the servers on the shared 28-bit divider, which yields
// one quotient bit per cycle (a division is skipped where its quotient is zero).
// A new transaction is taken while the previous result waits in the output register.
// Synchronous active-low reset: registers to 2500/1000, occupancy, weights, offsets and counts to zero.
`default_nettype none

module weighted_server_select #(
    parameter int NUM_SERVERS = 5
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wss_in_if.sink      i_in,
    wss_out_if.source   o_out,
    wss_cfg_if.sink     i_cfg
);

    wss_pkg::t_dp_cmd     w_cmd;
    wss_pkg::t_dp_status  w_status;
    logic                 w_in_ready;

    // Configuration writes are taken at any time
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    wss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wss_datapath #(
        .NUM_SERVERS (NUM_SERVERS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .i_command          (i_in.command),
        .i_server_index     (i_in.server_index),
        .i_occupancy_value  (i_in.occupancy_value),
        .i_random_value     (i_in.random_value),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_selected_server  (o_out.selected_server),
        .o_interval_matched (o_out.interval_matched),
        .o_occupancy_after  (o_out.occupancy_after),
        .o_times_selected   (o_out.times_selected),
        .i_cmd              (w_cmd),
        .o_status           (w_status)
    );

endmodule

`default_nettype wire
